>>> sv/dmbe_pkg.sv
// Shared types, constants and codes of the dot-matrix band encoder.
`timescale 1ns / 1ps
`default_nettype none

package dmbe_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int Q_DEPTH       = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;
    localparam int CMD_W      = 2;
    localparam int PIX_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int PIN_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd640;
    localparam logic [IMG_H_W-1:0] IMG_H_RST = 16'd480;
    localparam logic [PIN_W-1:0]   PIN_TOP   = 3'd7;

    localparam logic [11:0] DOT_MASK = 12'hfff;

    localparam int MODE_T1 = 725;
    localparam int MODE_T2 = 644;
    localparam int MODE_T3 = 580;
    localparam logic [BYTE_W-1:0] MODE_A = 8'd2;
    localparam logic [BYTE_W-1:0] MODE_B = 8'd6;
    localparam logic [BYTE_W-1:0] MODE_C = 8'd4;
    localparam logic [BYTE_W-1:0] MODE_D = 8'd5;

    localparam logic [BYTE_W-1:0] B_LF   = 8'd10;
    localparam logic [BYTE_W-1:0] B_CR   = 8'd13;
    localparam logic [BYTE_W-1:0] B_ESC  = 8'd27;
    localparam logic [BYTE_W-1:0] B_STAR = 8'd42;
    localparam logic [BYTE_W-1:0] B_AT   = 8'd64;
    localparam logic [BYTE_W-1:0] B_J    = 8'd74;
    localparam logic [BYTE_W-1:0] B_FEED = 8'd24;

    localparam int HEAD_LEN = 6;
    localparam int TAIL_LEN = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_PULL  = 2'd2,
        CMD_END   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HEAD = 2'd1,
        PH_DATA = 2'd2,
        PH_TAIL = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        K_SINGLE = 2'd0,
        K_START  = 2'd1,
        K_END    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              ram_en;
        logic              ram_clr;
        logic              from_ram;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] mask;
        logic              valid;
        logic              last;
        logic              pending;
        t_status           status;
    } t_op;

endpackage

`default_nettype wire

>>> sv/dmbe_intf.sv
// Input and output channel interfaces of the dot-matrix band encoder.
`timescale 1ns / 1ps
`default_nettype none

interface dmbe_in_if;
    import dmbe_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [PIX_W-1:0] pixel;
    modport source (output valid, command, pixel, input ready);
    modport sink   (input valid, command, pixel, output ready);
endinterface

interface dmbe_out_if;
    import dmbe_pkg::*;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                out_valid;
    logic                last_of_record;
    logic                band_pending;
    logic [STATUS_W-1:0] status;
    modport source (output valid, out_byte, out_valid, last_of_record, band_pending, status,
                    input ready);
    modport sink   (input valid, out_byte, out_valid, last_of_record, band_pending, status,
                    output ready);
endinterface

`default_nettype wire

>>> sv/dmbe_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps
`default_nettype none

module dmbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/dmbe_queue.sv
// Short operation queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module dmbe_queue #(
    parameter int AW    = 11,
    parameter int DEPTH = dmbe_pkg::Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dmbe_pkg::t_op i_op,
    input  logic [AW-1:0] i_arg,
    output logic          o_ready,
    output logic          o_valid,
    output dmbe_pkg::t_op o_op,
    output logic [AW-1:0] o_arg,
    input  logic          i_pop
);
    import dmbe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW:0]   CNT_FULL = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    t_op           r_op_mem  [DEPTH];
    logic [AW-1:0] r_arg_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [PW:0]   r_count, n_count;
    logic          do_pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_op    = r_op_mem[r_rptr];
    assign o_arg   = r_arg_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + (PW + 1)'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - (PW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_op_mem[r_wptr]  <= i_op;
            r_arg_mem[r_wptr] <= i_arg;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_FULL))
        else $error("queue push while full");

endmodule

`default_nettype wire

>>> sv/dmbe_front.sv
// Front: accepts commands, keeps band and record state, issues operations.
`timescale 1ns / 1ps
`default_nettype none

module dmbe_front #(
    parameter int MAX_WIDTH = dmbe_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dmbe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dmbe_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    dmbe_in_if.sink                            i_in,
    input  logic                               i_init_busy,
    input  logic                               i_q_ready,
    output logic                               o_q_valid,
    output dmbe_pkg::t_op                      o_q_op,
    output logic [$clog2(MAX_WIDTH):0]         o_q_arg
);
    import dmbe_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = CW + 1;
    localparam int EW = (LW > IMG_W_W) ? LW : IMG_W_W;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_WIDTH);

    logic [IMG_W_W-1:0] r_width, n_width;
    logic [IMG_H_W-1:0] r_height, n_height;
    logic [CW-1:0]      r_col, n_col;
    logic [IMG_H_W-1:0] r_row, n_row;
    logic [PIN_W-1:0]   r_pin, n_pin;
    logic [LW-1:0]      r_used, n_used;
    logic [LW-1:0]      r_pos, n_pos;
    t_phase             r_phase, n_phase;

    logic               accept;
    t_cmd               cmd;
    logic [EW-1:0]      w_ext;
    logic [EW-1:0]      w_clamp;
    logic [LW-1:0]      w_eff;
    logic [EW-1:0]      w_cmp;
    logic [BYTE_W-1:0]  mode;
    logic [LW-1:0]      col1;
    logic               dot;
    logic [IMG_H_W:0]   row1;
    logic               last_row;
    logic [LW-1:0]      pos1;
    logic [15:0]        len16;
    logic [BYTE_W-1:0]  head_byte;
    logic [BYTE_W-1:0]  tail_byte;
    t_op                q_op;
    logic [LW-1:0]      q_arg;

    assign i_in.ready = !i_init_busy && i_q_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign cmd        = t_cmd'(i_in.command);

    assign w_ext   = EW'(r_width);
    assign w_clamp = (w_ext > MAX_E) ? MAX_E : w_ext;
    assign w_eff   = (r_width == '0) ? LW'(1) : LW'(w_clamp);
    assign w_cmp   = EW'(w_eff);
    assign mode    = (w_cmp > EW'(MODE_T1)) ? MODE_A :
                     (w_cmp > EW'(MODE_T2)) ? MODE_B :
                     (w_cmp > EW'(MODE_T3)) ? MODE_C : MODE_D;

    assign col1     = LW'(r_col) + LW'(1);
    assign dot      = (i_in.pixel[11:0] != DOT_MASK);
    assign row1     = {1'b0, r_row} + (IMG_H_W + 1)'(1);
    assign last_row = (row1 >= {1'b0, r_height});
    assign pos1     = r_pos + LW'(1);
    assign len16    = 16'(r_used);

    always_comb begin
        unique case (r_pos)
            LW'(0):  head_byte = B_CR;
            LW'(1):  head_byte = B_ESC;
            LW'(2):  head_byte = B_STAR;
            LW'(3):  head_byte = mode;
            LW'(4):  head_byte = len16[7:0];
            default: head_byte = len16[15:8];
        endcase
    end

    assign tail_byte = (r_pos == '0) ? B_ESC : (r_pos == LW'(1)) ? B_J : B_FEED;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_pin    = r_pin;
        n_used   = r_used;
        n_pos    = r_pos;
        n_phase  = r_phase;
        q_op        = '0;
        q_op.kind   = K_SINGLE;
        q_op.status = ST_OK;
        q_arg       = '0;

        if (i_cfg_we && i_cfg_idx == CFG_IMAGE_WIDTH) begin
            n_width = i_cfg_data[IMG_W_W-1:0];
        end
        if (i_cfg_we && i_cfg_idx == CFG_IMAGE_HEIGHT) begin
            n_height = i_cfg_data[IMG_H_W-1:0];
        end

        if (accept) begin
            unique case (cmd)
                CMD_START: begin
                    q_op.kind = K_START;
                    q_arg     = r_used;
                    n_col     = '0;
                    n_row     = '0;
                    n_pin     = PIN_TOP;
                    n_used    = '0;
                    n_pos     = '0;
                    n_phase   = PH_IDLE;
                end
                CMD_END: begin
                    q_op.kind = K_END;
                end
                CMD_PIXEL: begin
                    if (r_phase != PH_IDLE) begin
                        q_op.status = ST_REFUSED;
                    end else begin
                        q_op.ram_en = 1'b1;
                        q_op.mask   = dot ? (BYTE_W'(1) << r_pin) : '0;
                        q_arg       = LW'(r_col);
                        if (dot && r_used < col1) begin
                            n_used = col1;
                        end
                        if (col1 < w_eff) begin
                            n_col = col1[CW-1:0];
                        end else begin
                            n_col = '0;
                            if (r_pin != '0 && !last_row) begin
                                n_pin = r_pin - PIN_W'(1);
                                n_row = row1[IMG_H_W-1:0];
                            end else begin
                                n_row   = last_row ? '0 : row1[IMG_H_W-1:0];
                                n_pin   = PIN_TOP;
                                n_phase = PH_HEAD;
                                n_pos   = '0;
                            end
                        end
                    end
                end
                CMD_PULL: begin
                    q_op.valid = 1'b1;
                    unique case (r_phase)
                        PH_IDLE: begin
                            q_op.valid  = 1'b0;
                            q_op.status = ST_EMPTY;
                        end
                        PH_HEAD: begin
                            q_op.data = head_byte;
                            if (pos1 >= LW'(HEAD_LEN)) begin
                                n_pos   = '0;
                                n_phase = (r_used != '0) ? PH_DATA : PH_TAIL;
                            end else begin
                                n_pos = pos1;
                            end
                        end
                        PH_DATA: begin
                            q_op.ram_en   = 1'b1;
                            q_op.ram_clr  = 1'b1;
                            q_op.from_ram = 1'b1;
                            q_arg         = r_pos;
                            if (pos1 >= r_used) begin
                                n_pos   = '0;
                                n_phase = PH_TAIL;
                            end else begin
                                n_pos = pos1;
                            end
                        end
                        PH_TAIL: begin
                            q_op.data = tail_byte;
                            if (pos1 >= LW'(TAIL_LEN)) begin
                                q_op.last = 1'b1;
                                n_pos     = '0;
                                n_used    = '0;
                                n_phase   = PH_IDLE;
                            end else begin
                                n_pos = pos1;
                            end
                        end
                    endcase
                end
            endcase
        end
        q_op.pending = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= IMG_W_RST;
            r_height <= IMG_H_RST;
            r_col    <= '0;
            r_row    <= '0;
            r_pin    <= PIN_TOP;
            r_used   <= '0;
            r_pos    <= '0;
            r_phase  <= PH_IDLE;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pin    <= n_pin;
            r_used   <= n_used;
            r_pos    <= n_pos;
            r_phase  <= n_phase;
        end
    end

    assign o_q_valid = accept;
    assign o_q_op    = q_op;
    assign o_q_arg   = q_arg;

    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_pos == '0))
        else $error("record position not cleared while idle");

    a_data_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_pos < r_used))
        else $error("column read past used length");

endmodule

`default_nettype wire

>>> sv/dmbe_back.sv
// Back: column store access, clearing passes and output beat register.
`timescale 1ns / 1ps
`default_nettype none

module dmbe_back #(
    parameter int MAX_WIDTH = dmbe_pkg::MAX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    output logic                       o_q_ready,
    input  dmbe_pkg::t_op              i_q_op,
    input  logic [$clog2(MAX_WIDTH):0] i_q_arg,
    output logic                       o_init_busy,
    dmbe_out_if.source                 o_out
);
    import dmbe_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = CW + 1;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_WIDTH);

    logic                r_init;
    logic [LW-1:0]       r_clr_left;
    logic                r_s1_vld;
    t_op                 r_s1_op;
    logic [LW-1:0]       r_s1_arg;
    logic [1:0]          r_beat;
    logic                r_fwd_hit;
    logic [BYTE_W-1:0]   r_fwd_data;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_bv;
    logic                r_out_last;
    logic                r_out_pend;
    t_status             r_out_stat;

    logic                clr_busy;
    logic [LW-1:0]       clr_dec;
    logic [BYTE_W-1:0]   old;
    logic [1:0]          beat_last;
    logic                is_last;
    logic                emit;
    logic                s1_done;
    logic                s1_free;
    logic                pop;
    logic                ram_we;
    logic [CW-1:0]       ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [CW-1:0]       ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;
    logic [BYTE_W-1:0]   beat_byte;
    logic                beat_bv;
    logic                beat_lastrec;

    assign clr_busy  = (r_clr_left != '0);
    assign clr_dec   = r_clr_left - LW'(1);
    assign old       = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign beat_last = (r_s1_op.kind == K_START) ? 2'd2 :
                       (r_s1_op.kind == K_END)   ? 2'd1 : 2'd0;
    assign is_last   = (r_beat == beat_last);
    assign emit      = r_s1_vld && !clr_busy && (!r_out_valid || o_out.ready);
    assign s1_done   = emit && is_last;
    assign s1_free   = !r_s1_vld || s1_done;
    assign pop       = i_q_valid && s1_free;
    assign o_q_ready = s1_free;

    assign ram_we    = clr_busy || (s1_done && r_s1_op.ram_en);
    assign ram_waddr = clr_busy ? clr_dec[CW-1:0] : r_s1_arg[CW-1:0];
    assign ram_wdata = (clr_busy || r_s1_op.ram_clr) ? '0 : (old | r_s1_op.mask);
    assign ram_re    = pop && i_q_op.ram_en;
    assign ram_raddr = i_q_arg[CW-1:0];

    dmbe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        unique case (r_s1_op.kind)
            K_START: begin
                beat_byte    = (r_beat == 2'd0) ? B_LF : (r_beat == 2'd1) ? B_ESC : B_AT;
                beat_bv      = 1'b1;
                beat_lastrec = is_last;
            end
            K_END: begin
                beat_byte    = (r_beat == 2'd0) ? B_ESC : B_AT;
                beat_bv      = 1'b1;
                beat_lastrec = is_last;
            end
            default: begin
                beat_byte    = r_s1_op.from_ram ? old : r_s1_op.data;
                beat_bv      = r_s1_op.valid;
                beat_lastrec = r_s1_op.last;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b1;
            r_clr_left  <= MAX_L;
            r_s1_vld    <= 1'b0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!clr_busy) begin
                r_init <= 1'b0;
            end
            if (pop && i_q_op.kind == K_START) begin
                r_clr_left <= i_q_arg;
            end else if (clr_busy) begin
                r_clr_left <= clr_dec;
            end
            if (pop) begin
                r_s1_vld <= 1'b1;
                r_beat   <= '0;
            end else if (s1_done) begin
                r_s1_vld <= 1'b0;
            end else if (emit) begin
                r_beat <= r_beat + 2'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_op  <= i_q_op;
            r_s1_arg <= i_q_arg;
        end
        if (ram_re) begin
            r_fwd_hit  <= ram_we && (ram_waddr == ram_raddr);
            r_fwd_data <= ram_wdata;
        end
        if (emit) begin
            r_out_byte <= beat_byte;
            r_out_bv   <= beat_bv;
            r_out_last <= beat_lastrec;
            r_out_pend <= r_s1_op.pending;
            r_out_stat <= r_s1_op.status;
        end
    end

    assign o_init_busy          = r_init;
    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.out_valid      = r_out_bv;
    assign o_out.last_of_record = r_out_last;
    assign o_out.band_pending   = r_out_pend;
    assign o_out.status         = r_out_stat;

    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !r_s1_vld)
        else $error("operation issued during power-up clearing pass");

endmodule

`default_nettype wire

>>> sv/dot_matrix_band_encoder_top.sv
// Top level of the dot-matrix band encoder: front, operation queue and back.
//
//  channel  | dir | beat contents                                         | handshake
//  ---------+-----+-------------------------------------------------------+------------
//  i_in     | in  | command, pixel                                        | valid/ready
//  o_out    | out | out_byte, out_valid, last_of_record, band_pending,    | valid/ready
//           |     | status                                                |
//  i_cfg_*  | in  | register index, write data                            | write enable
//
// One command beat per cycle while i_in.ready is high; a pixel or pull beat gives one
// output beat, end page two, and start page three, after a clearing pass of the band's
// used length (up to MAX_WIDTH columns) on the column store's write port. After reset
// the whole column store is cleared with i_in.ready low. A four-entry operation queue
// lets the input keep flowing while o_out stalls, until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module dot_matrix_band_encoder_top #(
    parameter int MAX_WIDTH = dmbe_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dmbe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dmbe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    dmbe_in_if.sink                         i_in,
    dmbe_out_if.source                      o_out
);
    import dmbe_pkg::*;

    localparam int LW = $clog2(MAX_WIDTH) + 1;

    logic          init_busy;
    logic          push;
    t_op           push_op;
    logic [LW-1:0] push_arg;
    logic          q_ready;
    logic          q_valid;
    t_op           q_op;
    logic [LW-1:0] q_arg;
    logic          q_pop;

    dmbe_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_init_busy (init_busy),
        .i_q_ready   (q_ready),
        .o_q_valid   (push),
        .o_q_op      (push_op),
        .o_q_arg     (push_arg)
    );

    dmbe_queue #(
        .AW    (LW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_arg   (push_arg),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_op),
        .o_arg   (q_arg),
        .i_pop   (q_pop)
    );

    dmbe_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_pop),
        .i_q_op      (q_op),
        .i_q_arg     (q_arg),
        .o_init_busy (init_busy),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
